### rtl/slot_allocator_reuse_delay_macros.svh
// Assertion macros for the slot allocator.
// Used at the end of slot_allocator_reuse_delay; expects clk and rst_n in scope.
`ifndef SLOT_ALLOCATOR_REUSE_DELAY_MACROS_SVH
`define SLOT_ALLOCATOR_REUSE_DELAY_MACROS_SVH

// Checked on every rising edge, held off while reset is asserted
`define SRA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, including during reset
`define SRA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/sra_pkg.sv
// Shared types and constants for the slot allocator.
// No dependencies; imported by sra_scan_eval and slot_allocator_reuse_delay.
package sra_pkg;

    localparam int TIME_W = 32;
    localparam int GAP_W  = 16;
    localparam int SLOT_W = 10;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;
    localparam int USER_W      = 2;

    // Register reset values
    localparam logic [GAP_W-1:0] GRACE_RESET = 16'd2000;
    localparam logic [GAP_W-1:0] DELAY_RESET = 16'd1000;

    // Register indexes
    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_GRACE = 2'd1;
    localparam logic [1:0] CFG_DELAY = 2'd2;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_ALLOC  = 2'd0,
        ST_FREED  = 2'd1,
        ST_PINNED = 2'd2,
        ST_FULL   = 2'd3
    } sra_status_t;

    // Verdict on one table entry during a scan
    typedef struct packed {
        logic is_free;   // not in use
        logic usable;    // not in use and out of quarantine
    } sra_eval_t;

endpackage

### rtl/sra_scan_eval.sv
// Qualification of one slot table entry read during an allocate scan.
// Depends on sra_pkg.
module sra_scan_eval
    import sra_pkg::*;
(
    input  logic              in_use,
    input  logic [TIME_W-1:0] free_time,
    input  logic [TIME_W-1:0] start_time,
    input  logic [GAP_W-1:0]  grace_period,
    input  logic [GAP_W-1:0]  reuse_delay,
    input  logic [TIME_W-1:0] now,
    output sra_eval_t         ev
);

    logic [TIME_W-1:0] age_since_start;
    logic [TIME_W-1:0] age_since_free;
    logic              quarantined;

    // Both differences wrap modulo 2^32
    assign age_since_start = free_time - start_time;
    assign age_since_free  = now - free_time;

    // Freed after the grace period and not rested long enough
    assign quarantined = (age_since_start > TIME_W'(grace_period))
                      && (age_since_free < TIME_W'(reuse_delay));

    assign ev.is_free = ~in_use;
    assign ev.usable  = ~in_use & ~quarantined;

endmodule

### rtl/slot_allocator_reuse_delay.sv
// Slot allocator with reuse quarantine: allocate/free requests against a slot table.
// Free requests go straight to the done state; allocate requests scan the opened slots above
// RESERVED_SLOTS with one table read per scanned slot, and an early hit ends the scan.
// Throughput: one request in flight, the next is taken the cycle after its result is posted;
// a result still waiting in the output register holds the sequencer until it is taken.
// Reset: async active low; then a clearing pass over all TOTAL_SLOTS entries, no request accepted.
module slot_allocator_reuse_delay
    import sra_pkg::*;
#(
    parameter int TOTAL_SLOTS     = 1024,
    parameter int RESERVED_SLOTS  = 64,
    parameter int TOP_SPARE_SLOTS = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Request stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [9:0] slot_index, [41:10] current_time
    input  logic [USER_W-1:0]      s_tuser,   // [0] kind, [1] pinned
    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [9:0] granted_slot, [19:10] high_water
    output logic [USER_W-1:0]      m_tuser,   // [1:0] status
    // Configuration writes
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [TIME_W-1:0]      cfg_data
);

    localparam int AW           = $clog2(TOTAL_SLOTS);
    localparam int OPEN_MAX     = (RESERVED_SLOTS > TOTAL_SLOTS) ? RESERVED_SLOTS : TOTAL_SLOTS;
    localparam int CW           = $clog2(OPEN_MAX + 1);
    localparam int GROWTH_LIMIT = TOTAL_SLOTS - TOP_SPARE_SLOTS;
    localparam logic [CW-1:0] RESV_C  = CW'(RESERVED_SLOTS);
    localparam logic [CW-1:0] LIMIT_C = CW'(GROWTH_LIMIT);
    localparam logic [CW-1:0] TOTAL_C = CW'(TOTAL_SLOTS);
    localparam logic [AW-1:0] LAST_C  = AW'(TOTAL_SLOTS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [AW-1:0]     clr_addr_reg;
    logic [TIME_W-1:0] start_time_reg;
    logic [GAP_W-1:0]  grace_reg;
    logic [GAP_W-1:0]  delay_reg;
    logic [TIME_W-1:0] now_reg;
    logic [CW-1:0]     open_count_reg;
    logic [CW-1:0]     scan_addr_reg;
    logic              rd_valid_reg;
    logic [AW-1:0]     rd_idx_reg;
    logic              hit_reg;
    logic [AW-1:0]     hit_slot_reg;
    logic              any_reg;
    logic [AW-1:0]     any_slot_reg;
    logic [AW-1:0]     res_slot_reg;
    sra_status_t       res_status_reg;
    logic              res_write_reg;
    logic              res_is_free_reg;
    logic              m_valid_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [SLOT_W-1:0] out_hw_reg;
    sra_status_t       out_status_reg;

    // Slot table: in-use bits and free times, registered read
    logic              use_mem [TOTAL_SLOTS];
    logic [TIME_W-1:0] time_mem [TOTAL_SLOTS];
    logic              rd_use_reg;
    logic [TIME_W-1:0] rd_time_reg;

    logic              issue;
    logic              done_fire;
    logic              accept;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              wr_use_en;
    logic              wr_use;
    logic              wr_time_en;
    logic [TIME_W-1:0] wr_time;
    logic [SLOT_W-1:0] in_idx;
    logic [TIME_W-1:0] in_time;
    logic              in_kind;
    logic              in_pin;
    logic              idx_ok;
    sra_eval_t         ev;

    // Request unpacking
    assign in_idx  = s_tdata[SLOT_W-1:0];
    assign in_time = s_tdata[SLOT_W+TIME_W-1:SLOT_W];
    assign in_kind = s_tuser[0];
    assign in_pin  = s_tuser[1];
    assign idx_ok  = (CW + SLOT_W)'(in_idx) < (CW + SLOT_W)'(TOTAL_C);

    // Handshakes
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid & s_tready;
    assign issue     = (state_reg == S_SCAN) && (scan_addr_reg != open_count_reg) && !hit_reg;
    assign done_fire = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    // Table port selection: clearing pass or commit of the finished request
    assign rd_addr = scan_addr_reg[AW-1:0];
    always_comb
    begin
        wr_addr    = res_slot_reg;
        wr_use     = ~res_is_free_reg;
        wr_time    = now_reg;
        wr_use_en  = done_fire & res_write_reg;
        wr_time_en = done_fire & res_write_reg & res_is_free_reg;
        if (state_reg == S_CLEAR)
        begin
            wr_addr    = clr_addr_reg;
            wr_use     = 1'b0;
            wr_time    = '0;
            wr_use_en  = 1'b1;
            wr_time_en = 1'b1;
        end
    end

    // Slot table memories
    always_ff @(posedge clk)
    begin
        if (wr_use_en)
        begin
            use_mem[wr_addr] <= wr_use;
        end
        if (wr_time_en)
        begin
            time_mem[wr_addr] <= wr_time;
        end
        if (issue)
        begin
            rd_use_reg  <= use_mem[rd_addr];
            rd_time_reg <= time_mem[rd_addr];
        end
    end

    // Entry qualification
    sra_scan_eval u_eval (
        .in_use       (rd_use_reg),
        .free_time    (rd_time_reg),
        .start_time   (start_time_reg),
        .grace_period (grace_reg),
        .reuse_delay  (delay_reg),
        .now          (now_reg),
        .ev           (ev)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg <= '0;
            grace_reg      <= GRACE_RESET;
            delay_reg      <= DELAY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START: start_time_reg <= cfg_data;
                CFG_GRACE: grace_reg      <= cfg_data[GAP_W-1:0];
                CFG_DELAY: delay_reg      <= cfg_data[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Control sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_addr_reg    <= '0;
            now_reg         <= '0;
            open_count_reg  <= RESV_C;
            scan_addr_reg   <= '0;
            rd_valid_reg    <= 1'b0;
            rd_idx_reg      <= '0;
            hit_reg         <= 1'b0;
            hit_slot_reg    <= '0;
            any_reg         <= 1'b0;
            any_slot_reg    <= '0;
            res_slot_reg    <= '0;
            res_status_reg  <= ST_FULL;
            res_write_reg   <= 1'b0;
            res_is_free_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
            out_slot_reg    <= '0;
            out_hw_reg      <= '0;
            out_status_reg  <= ST_FULL;
        end
        else
        begin
            // Result taken and nothing new posted this cycle
            if (m_valid_reg && m_tready && !done_fire)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == LAST_C)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        now_reg <= in_time;
                        if (in_kind == KIND_FREE)
                        begin
                            res_slot_reg    <= AW'(in_idx);
                            res_status_reg  <= in_pin ? ST_PINNED : ST_FREED;
                            res_write_reg   <= ~in_pin & idx_ok;
                            res_is_free_reg <= 1'b1;
                            state_reg       <= S_DONE;
                        end
                        else
                        begin
                            scan_addr_reg <= RESV_C;
                            rd_valid_reg  <= 1'b0;
                            hit_reg       <= 1'b0;
                            any_reg       <= 1'b0;
                            state_reg     <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    // One read issued per cycle, judged the cycle after
                    rd_valid_reg <= issue;
                    rd_idx_reg   <= scan_addr_reg[AW-1:0];
                    if (issue)
                    begin
                        scan_addr_reg <= scan_addr_reg + 1'b1;
                    end
                    if (rd_valid_reg)
                    begin
                        if (ev.usable && !hit_reg)
                        begin
                            hit_reg      <= 1'b1;
                            hit_slot_reg <= rd_idx_reg;
                        end
                        if (ev.is_free && !any_reg)
                        begin
                            any_reg      <= 1'b1;
                            any_slot_reg <= rd_idx_reg;
                        end
                    end
                    if (!issue && !rd_valid_reg)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    res_is_free_reg <= 1'b0;
                    // Quarantine-aware hit, then growth, then any free slot
                    if (hit_reg)
                    begin
                        res_slot_reg   <= hit_slot_reg;
                        res_write_reg  <= 1'b1;
                        res_status_reg <= ST_ALLOC;
                    end
                    else if (open_count_reg < LIMIT_C)
                    begin
                        res_slot_reg   <= open_count_reg[AW-1:0];
                        res_write_reg  <= 1'b1;
                        res_status_reg <= ST_ALLOC;
                        open_count_reg <= open_count_reg + 1'b1;
                    end
                    else if (any_reg)
                    begin
                        res_slot_reg   <= any_slot_reg;
                        res_write_reg  <= 1'b1;
                        res_status_reg <= ST_ALLOC;
                    end
                    else
                    begin
                        res_slot_reg   <= '0;
                        res_write_reg  <= 1'b0;
                        res_status_reg <= ST_FULL;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (done_fire)
                    begin
                        m_valid_reg    <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_slot_reg   <= (res_status_reg == ST_ALLOC)
                                          ? SLOT_W'(res_slot_reg) : '0;
                        out_hw_reg     <= SLOT_W'(open_count_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result packing
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 2*SLOT_W){1'b0}}, out_hw_reg, out_slot_reg};
    assign m_tuser  = out_status_reg;

`include "slot_allocator_reuse_delay_macros.svh"

    // High-water mark only ever steps up by one
    `SRA_ASSERT(a_open_step,
        (open_count_reg != $past(open_count_reg))
            |-> (open_count_reg == $past(open_count_reg) + 1'b1),
        "open_count moved by more than one")

    // A grant always lies in the opened, unreserved range
    `SRA_ASSERT(a_grant_range,
        (state_reg == S_DONE && res_status_reg == ST_ALLOC)
            |-> (CW'(res_slot_reg) >= RESV_C && CW'(res_slot_reg) < open_count_reg),
        "grant outside opened range")

    // An accepted request always leaves the idle state
    `SRA_ASSERT(a_busy_after_accept, accept |=> (state_reg != S_IDLE),
        "sequencer stayed idle after a request")

    // No table commit while the clearing pass runs
    `SRA_ASSERT_ALWAYS(a_no_commit_in_clear, !(state_reg == S_CLEAR && done_fire),
        "commit during clearing pass")

endmodule

### test/testbench.sv
// Self-checking testbench for slot_allocator_reuse_delay: allocate/free requests
// are checked against an in-bench model of the slot table and quarantine rules.
// Depends on sra_pkg and the slot_allocator_reuse_delay RTL.
`timescale 1ns / 1ps

module testbench;
    import sra_pkg::*;

    localparam int TOTAL_SLOTS     = 1024;
    localparam int RESERVED_SLOTS  = 64;
    localparam int TOP_SPARE_SLOTS = 2;
    localparam int GROWTH_LIMIT    =
        (TOP_SPARE_SLOTS >= TOTAL_SLOTS) ? 0 : TOTAL_SLOTS - TOP_SPARE_SLOTS;

    // Index with no register behind it
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot_index;
        logic              pinned;
        logic [TIME_W-1:0] now;
    } slot_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        sra_status_t       status;
        logic [SLOT_W-1:0] high_water;
    } slot_reply_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // [9:0] slot_index, [41:10] current_time
    logic [USER_W-1:0]      s_tuser   = '0;   // [0] kind, [1] pinned
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [9:0] granted_slot, [19:10] high_water
    logic [USER_W-1:0]      m_tuser;          // [1:0] status
    logic                   cfg_we    = 1'b0;
    logic [1:0]             cfg_index = '0;
    logic [TIME_W-1:0]      cfg_data  = '0;

    // Model state: slot table, high-water mark, register copies
    bit                     slot_busy [TOTAL_SLOTS];
    bit [TIME_W-1:0]        slot_freed_at [TOTAL_SLOTS];
    int                     open_cnt = RESERVED_SLOTS;
    bit [TIME_W-1:0]        start_ms = '0;
    bit [GAP_W-1:0]         grace_ms = GRACE_RESET;
    bit [GAP_W-1:0]         delay_ms = DELAY_RESET;

    slot_req_t              request_queue [$];
    slot_reply_t            reply_queue [$];
    slot_req_t              drive_req;
    bit                     have_req     = 1'b0;
    bit                     req_accepted = 1'b0;
    int                     send_idle_pct  = 0;
    int                     recv_stall_pct = 0;
    int                     fail_count     = 0;
    logic [TIME_W-1:0]      sim_ms = '0;

    slot_allocator_reuse_delay #(
        .TOTAL_SLOTS     (TOTAL_SLOTS),
        .RESERVED_SLOTS  (RESERVED_SLOTS),
        .TOP_SPARE_SLOTS (TOP_SPARE_SLOTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // First open slot from the bottom of the normal range; -1 if none qualifies
    function automatic int find_slot(bit with_delay, logic [TIME_W-1:0] now);
        int                top;
        logic [TIME_W-1:0] since_start;
        logic [TIME_W-1:0] resting;
        top = (open_cnt < TOTAL_SLOTS) ? open_cnt : TOTAL_SLOTS;
        for (int i = RESERVED_SLOTS; i < top; i++)
        begin
            since_start = slot_freed_at[i] - start_ms;
            resting     = now - slot_freed_at[i];
            if (!slot_busy[i] &&
                !(with_delay && since_start > grace_ms && resting < delay_ms))
                return i;
        end
        return -1;
    endfunction

    // Apply one request to the model table and return the reply it should produce
    function automatic slot_reply_t serve_request(slot_req_t r);
        slot_reply_t rep;
        int          s;
        rep.slot = '0;
        if (r.kind == KIND_FREE)
        begin
            if (r.pinned)
                rep.status = ST_PINNED;
            else
            begin
                rep.status = ST_FREED;
                if (r.slot_index < TOTAL_SLOTS)
                begin
                    slot_freed_at[r.slot_index] = r.now;
                    slot_busy[r.slot_index]     = 1'b0;
                end
            end
        end
        else
        begin
            s = find_slot(1'b1, r.now);
            if (s < 0)
            begin
                // grow while below the limit, else retry ignoring quarantine
                if (open_cnt < GROWTH_LIMIT && open_cnt < TOTAL_SLOTS)
                begin
                    s = open_cnt;
                    open_cnt++;
                end
                else
                    s = find_slot(1'b0, r.now);
            end
            if (s < 0)
                rep.status = ST_FULL;
            else
            begin
                slot_busy[s] = 1'b1;
                rep.slot     = s[SLOT_W-1:0];
                rep.status   = ST_ALLOC;
            end
        end
        rep.high_water = open_cnt[SLOT_W-1:0];
        return rep;
    endfunction

    // Request driver: holds valid until taken, random gaps between requests
    always @(negedge clk)
    begin
        if (req_accepted)
        begin
            req_accepted = 1'b0;
            have_req     = 1'b0;
        end
        if (rst_n && !have_req && request_queue.size() != 0 &&
            $urandom_range(99) >= send_idle_pct)
        begin
            drive_req = request_queue.pop_front();
            s_tdata  <= {{(IN_TDATA_W - TIME_W - SLOT_W){1'b0}}, drive_req.now,
                         drive_req.slot_index};
            s_tuser  <= {drive_req.pinned, drive_req.kind};
            have_req  = 1'b1;
        end
        s_tvalid <= have_req;
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin : monitor
        slot_req_t   seen;
        slot_reply_t want;
        if (rst_n && s_tvalid && s_tready)
        begin
            seen.kind       = s_tuser[0];
            seen.pinned     = s_tuser[1];
            seen.slot_index = s_tdata[SLOT_W-1:0];
            seen.now        = s_tdata[SLOT_W +: TIME_W];
            reply_queue.push_back(serve_request(seen));
            req_accepted = 1'b1;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (reply_queue.size() == 0)
            begin
                $error("result with no request outstanding: %h/%h", m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                want = reply_queue.pop_front();
                if (m_tdata[SLOT_W-1:0] !== want.slot)
                begin
                    $error("granted_slot mismatch: expected %0d, got %0d",
                           want.slot, m_tdata[SLOT_W-1:0]);
                    fail_count++;
                end
                if (m_tuser !== want.status)
                begin
                    $error("status mismatch: expected %0d, got %0d", want.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata[SLOT_W +: SLOT_W] !== want.high_water)
                begin
                    $error("high_water mismatch: expected %0d, got %0d",
                           want.high_water, m_tdata[SLOT_W +: SLOT_W]);
                    fail_count++;
                end
            end
        end
    end

    task automatic set_pace(int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Register write; the block is idle, so the model copy updates at once
    task automatic write_reg(logic [1:0] idx, logic [TIME_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_START: start_ms = val;
            CFG_GRACE: grace_ms = val[GAP_W-1:0];
            CFG_DELAY: delay_ms = val[GAP_W-1:0];
            default: ;
        endcase
    endtask

    // Short lookahead so the generator sees a nearly current table
    task automatic send(logic kind, logic [SLOT_W-1:0] idx, logic pin, logic [TIME_W-1:0] t);
        slot_req_t r;
        r.kind       = kind;
        r.slot_index = idx;
        r.pinned     = pin;
        r.now        = t;
        while (request_queue.size() >= 2)
            @(posedge clk);
        request_queue.push_back(r);
    endtask

    // Time creeps forward with rare jumps; frees mostly target opened slots
    task automatic random_request(int alloc_pct);
        logic [SLOT_W-1:0] idx;
        logic              kind;
        int                pick;
        if ($urandom_range(99) < 5)
            sim_ms = $urandom;
        else
            sim_ms = sim_ms + $urandom_range(400);
        kind = ($urandom_range(99) < alloc_pct) ? KIND_ALLOC : KIND_FREE;
        pick = $urandom_range(99);
        if (kind == KIND_ALLOC)
            idx = SLOT_W'($urandom);
        else if (pick < 80 && open_cnt > RESERVED_SLOTS)
            idx = SLOT_W'($urandom_range(open_cnt - 1, RESERVED_SLOTS));
        else if (pick < 90)
            idx = SLOT_W'($urandom_range(RESERVED_SLOTS - 1, 0));
        else
            idx = SLOT_W'($urandom);
        send(kind, idx, $urandom_range(99) < 10, sim_ms);
    endtask

    task automatic wait_idle();
        while (request_queue.size() != 0 || have_req || reply_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int n;
        int guard;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: default registers (start 0, grace 2000, delay 1000)
        set_pace(0, 0);
        send(KIND_ALLOC, 10'd0, 1'b0, 32'd0);
        send(KIND_ALLOC, 10'd0, 1'b0, 32'd10);
        send(KIND_FREE, 10'd64, 1'b0, 32'd100);      // freed inside grace: reusable at once
        send(KIND_ALLOC, 10'd0, 1'b0, 32'd150);
        send(KIND_FREE, 10'd65, 1'b1, 32'd200);      // pinned, ignored
        send(KIND_FREE, 10'd3, 1'b0, 32'd300);       // reserved slot
        send(KIND_FREE, 10'd1023, 1'b0, 32'd400);    // above high-water, not in use
        send(KIND_ALLOC, 10'd0, 1'b0, 32'd500);
        send(KIND_FREE, 10'd65, 1'b0, 32'd5000);
        send(KIND_ALLOC, 10'd0, 1'b0, 32'd5500);     // 65 quarantined, grows
        send(KIND_FREE, 10'd66, 1'b0, 32'd6000);
        send(KIND_ALLOC, 10'd0, 1'b0, 32'd6999);     // 65 rested
        send(KIND_ALLOC, 10'd0, 1'b0, 32'd6999);     // 66 one ms short
        send(KIND_ALLOC, 10'd0, 1'b0, 32'd7000);     // 66 rested exactly the delay
        send(KIND_FREE, 10'd67, 1'b0, 32'd2000);     // freed exactly at grace end
        send(KIND_ALLOC, 10'd0, 1'b0, 32'd2001);
        send(KIND_FREE, 10'd67, 1'b0, 32'd2001);     // one ms past grace
        send(KIND_ALLOC, 10'd0, 1'b0, 32'd2002);
        send(KIND_FREE, 10'd0, 1'b0, 32'hFFFF_FFFF);
        send(KIND_FREE, 10'h3FF, 1'b1, 32'hFFFF_FFFF);
        send(KIND_ALLOC, 10'h3FF, 1'b1, 32'hFFFF_FFFF);
        wait_idle();

        // Mixed traffic, default registers
        repeat (25) random_request(60);
        wait_idle();

        // Quarantine always on, longest delay; sender gaps
        write_reg(CFG_START, sim_ms);
        write_reg(CFG_GRACE, 32'd0);
        write_reg(CFG_DELAY, 32'h0000_FFFF);
        set_pace(70, 0);
        repeat (25) random_request(40);
        wait_idle();

        // Longest grace, zero delay (upper data bits ignored); receiver stalls
        write_reg(CFG_START, 32'hFFFF_FFFF);
        write_reg(CFG_GRACE, 32'h0000_FFFF);
        write_reg(CFG_DELAY, 32'hFFFF_0000);
        set_pace(0, 70);
        repeat (25) random_request(55);
        wait_idle();

        // Random registers, plus a write to the unused index
        write_reg(CFG_START, $urandom);
        write_reg(CFG_GRACE, $urandom);
        write_reg(CFG_DELAY, ($urandom & 32'hFFFF_0000) | $urandom_range(3000));
        write_reg(CFG_UNUSED, $urandom);
        set_pace(13, 13);
        repeat (25) random_request(50);
        wait_idle();

        // Fill the table up to the growth limit with allocations, cycling the pacing
        write_reg(CFG_START, 32'd0);
        write_reg(CFG_GRACE, 32'd0);
        write_reg(CFG_DELAY, 32'd2000);
        n = 0;
        while (open_cnt < GROWTH_LIMIT && n < 1100)
        begin
            case ((n / 150) % 4)
                0: set_pace(0, 0);
                1: set_pace(70, 0);
                2: set_pace(0, 70);
                default: set_pace(13, 13);
            endcase
            random_request(100);
            n++;
        end
        wait_idle();

        // At the limit: quarantine forces the second scan, then table full
        write_reg(CFG_DELAY, 32'h0000_FFFF);
        set_pace(13, 13);
        repeat (30) random_request(60);
        wait_idle();
        write_reg(CFG_DELAY, 32'd0);
        set_pace(0, 0);
        repeat (15) random_request(60);

        // Drain with a bound, then settle
        while (request_queue.size() != 0 || have_req)
            @(posedge clk);
        for (guard = 0; guard < 5000 && reply_queue.size() != 0; guard++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (reply_queue.size() != 0)
        begin
            $error("%0d results never returned", reply_queue.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #150_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
